@@ src/psph_pkg.sv @@
package psph_pkg;

	localparam int COORD_W = 17;
	localparam int WORD_W  = 32;

	localparam logic [WORD_W-1:0] JX_MUL  = 32'd1233;
	localparam logic [WORD_W-1:0] JX_MOD  = 32'd171;
	localparam logic [WORD_W-1:0] JY_MUL  = 32'd453;
	localparam logic [WORD_W-1:0] JY_MOD  = 32'd765;
	localparam logic [WORD_W-1:0] LCG_MUL = 32'd1664525;
	localparam logic [WORD_W-1:0] LCG_ADD = 32'd1013904223;
	localparam int                XS_SHIFT = 16;

	// floor(2^39/171) and floor(2^41/765): quotient estimate is exact or one low
	localparam logic [WORD_W-1:0] RECIP_X = 32'd3214946280;
	localparam logic [WORD_W-1:0] RECIP_Y = 32'd2874540203;
	localparam int                QX_SHIFT = 39;
	localparam int                QY_SHIFT = 41;
	localparam int                QX_W = 2*WORD_W - QX_SHIFT;
	localparam int                QY_W = 2*WORD_W - QY_SHIFT;

	// raw remainder stays below twice the modulus
	localparam int RX_W = 9;
	localparam int RY_W = 11;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} coord_pair_t;

	typedef struct packed {
		word_t c;
		word_t b;
		word_t a;
	} triple_t;

endpackage

@@ src/psph_jitter.sv @@
module psph_jitter
	import psph_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  word_t       seed,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pixel_x,
	input  logic [15:0] pixel_y,
	input  word_t       iteration,
	output logic        out_valid,
	input  logic        out_ready,
	output coord_pair_t out_coord
);

	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	word_t               s_s1;
	logic [15:0]         px_s1, py_s1, px_s2, py_s2, px_s3, py_s3, px_s4, py_s4;
	word_t               mx_s2, my_s2;
	logic [QX_W-1:0]     qx_s3;
	logic [QY_W-1:0]     qy_s3;
	logic [RX_W-1:0]     mxl_s3, rx_s4;
	logic [RY_W-1:0]     myl_s3, ry_s4;
	coord_pair_t         coord_s5;

	logic [2*WORD_W-1:0] prod_x, prod_y;
	word_t               qmul_x, qmul_y;
	logic [RX_W-1:0]     rx_fix;
	logic [RY_W-1:0]     ry_fix;

	assign en_s5 = !vld_s5 || out_ready;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	always_comb begin
		prod_x = 64'(mx_s2) * 64'(RECIP_X);
		prod_y = 64'(my_s2) * 64'(RECIP_Y);
		qmul_x = 32'(qx_s3) * JX_MOD;
		qmul_y = 32'(qy_s3) * JY_MOD;
		// one correction step finishes the remainder
		rx_fix = (rx_s4 >= JX_MOD[RX_W-1:0]) ? rx_s4 - JX_MOD[RX_W-1:0] : rx_s4;
		ry_fix = (ry_s4 >= JY_MOD[RY_W-1:0]) ? ry_s4 - JY_MOD[RY_W-1:0] : ry_s4;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			s_s1  <= iteration + seed;
			px_s1 <= pixel_x;
			py_s1 <= pixel_y;
		end
		if (en_s2) begin
			mx_s2 <= s_s1 * JX_MUL;
			my_s2 <= s_s1 * JY_MUL;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
		end
		if (en_s3) begin
			qx_s3  <= prod_x[2*WORD_W-1:QX_SHIFT];
			qy_s3  <= prod_y[2*WORD_W-1:QY_SHIFT];
			mxl_s3 <= mx_s2[RX_W-1:0];
			myl_s3 <= my_s2[RY_W-1:0];
			px_s3  <= px_s2;
			py_s3  <= py_s2;
		end
		if (en_s4) begin
			rx_s4 <= mxl_s3 - qmul_x[RX_W-1:0];
			ry_s4 <= myl_s3 - qmul_y[RY_W-1:0];
			px_s4 <= px_s3;
			py_s4 <= py_s3;
		end
		if (en_s5) begin
			coord_s5.x <= COORD_W'(px_s4) + COORD_W'(rx_fix);
			coord_s5.y <= COORD_W'(py_s4) + COORD_W'(ry_fix);
		end
	end

	assign out_valid = vld_s5;
	assign out_coord = coord_s5;

endmodule

@@ src/psph_hash.sv @@
module psph_hash
	import psph_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  coord_pair_t in_coord,
	output logic        out_valid,
	input  logic        out_ready,
	output triple_t     out_rand
);

	logic en_s6, en_s7, en_s8, en_s9, en_s10, en_s11, en_s12;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;

	triple_t v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	triple_t u;
	word_t   lane_z;

	assign en_s12 = !vld_s12 || out_ready;
	assign en_s11 = !vld_s11 || en_s12;
	assign en_s10 = !vld_s10 || en_s11;
	assign en_s9  = !vld_s9  || en_s10;
	assign en_s8  = !vld_s8  || en_s9;
	assign en_s7  = !vld_s7  || en_s8;
	assign en_s6  = !vld_s6  || en_s7;
	assign in_ready = en_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			if (en_s6)  vld_s6  <= in_valid;
			if (en_s7)  vld_s7  <= vld_s6;
			if (en_s8)  vld_s8  <= vld_s7;
			if (en_s9)  vld_s9  <= vld_s8;
			if (en_s10) vld_s10 <= vld_s9;
			if (en_s11) vld_s11 <= vld_s10;
			if (en_s12) vld_s12 <= vld_s11;
		end
	end

	always_comb begin
		lane_z = WORD_W'(in_coord.x ^ in_coord.y);
		u.a = v_s9.a ^ (v_s9.a >> XS_SHIFT);
		u.b = v_s9.b ^ (v_s9.b >> XS_SHIFT);
		u.c = v_s9.c ^ (v_s9.c >> XS_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			v_s6.a <= WORD_W'(in_coord.x) * LCG_MUL + LCG_ADD;
			v_s6.b <= WORD_W'(in_coord.y) * LCG_MUL + LCG_ADD;
			v_s6.c <= lane_z * LCG_MUL + LCG_ADD;
		end
		// first mixing round, one lane per stage
		if (en_s7) begin
			v_s7.a <= v_s6.a + v_s6.b * v_s6.c;
			v_s7.b <= v_s6.b;
			v_s7.c <= v_s6.c;
		end
		if (en_s8) begin
			v_s8.a <= v_s7.a;
			v_s8.b <= v_s7.b + v_s7.c * v_s7.a;
			v_s8.c <= v_s7.c;
		end
		if (en_s9) begin
			v_s9.a <= v_s8.a;
			v_s9.b <= v_s8.b;
			v_s9.c <= v_s8.c + v_s8.a * v_s8.b;
		end
		// xor-shift folds into the first step of the second round
		if (en_s10) begin
			v_s10.a <= u.a + u.b * u.c;
			v_s10.b <= u.b;
			v_s10.c <= u.c;
		end
		if (en_s11) begin
			v_s11.a <= v_s10.a;
			v_s11.b <= v_s10.b + v_s10.c * v_s10.a;
			v_s11.c <= v_s10.c;
		end
		if (en_s12) begin
			v_s12.a <= v_s11.a;
			v_s12.b <= v_s11.b;
			v_s12.c <= v_s11.c + v_s11.a * v_s11.b;
		end
	end

	assign out_valid = vld_s12;
	assign out_rand  = v_s12;

endmodule

@@ src/pixel_seeded_pcg3d_hash_top.sv @@
// Channel      Direction  Payload (lowest bits first)
// s_axis       in         tdata: pixel_x[15:0], pixel_y[31:16], iteration[63:32]
// m_axis       out        tdata: rand_a[31:0], rand_b[63:32], rand_c[95:64]
// cfg          in         cfg_wdata: seed, written when cfg_we is high
//
// Twelve register stages; one item enters per cycle until a stall on m_axis backs up to the input.
// Jitter offsets: five stages. Hash: seven, s7-s12 with one 32x32 multiply-add each.
// Reset clears every stage valid bit and the seed.
// Each stage has its own enable, so a stall on m_axis backs up stage by stage
// and any empty stage keeps taking items until the chain is full.
module pixel_seeded_pcg3d_hash_top
	import psph_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // pixel_x, pixel_y, iteration
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // rand_a, rand_b, rand_c
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata       // seed
);

	word_t       seed_q;
	logic        jit_valid, hash_ready;
	coord_pair_t jit_coord;
	triple_t     rand_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	psph_jitter u_jitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.pixel_x   (s_axis_tdata[15:0]),
		.pixel_y   (s_axis_tdata[31:16]),
		.iteration (s_axis_tdata[63:32]),
		.out_valid (jit_valid),
		.out_ready (hash_ready),
		.out_coord (jit_coord)
	);

	psph_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (jit_valid),
		.in_ready  (hash_ready),
		.in_coord  (jit_coord),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rand  (rand_out)
	);

	assign m_axis_tdata = rand_out;

	// an empty output stage means nothing can block the chain
	a_empty_tail_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	a_sink_ready_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is drained");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without an output stall");

endmodule

@@ tb/sv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psph_pkg::word_t;
	import psph_pkg::triple_t;

	localparam word_t JIT_X_MUL = 32'd1233;
	localparam word_t JIT_X_MOD = 32'd171;
	localparam word_t JIT_Y_MUL = 32'd453;
	localparam word_t JIT_Y_MOD = 32'd765;
	localparam word_t MIX_LCG_MUL = 32'd1664525;
	localparam word_t MIX_LCG_INC = 32'd1013904223;
	localparam int MIX_SHIFT = 16;
	localparam int MAX_CYCLES = 200000;
	localparam int REPORT_LIMIT = 10;

	class hash_scoreboard;
		word_t seed;
		triple_t expected_q[$];
		int errors;
		int checked;

		function new();
			seed = '0;
			errors = 0;
			checked = 0;
		endfunction

		function triple_t hash_sample(logic [15:0] px, logic [15:0] py, word_t iter);
			word_t sum, jx, jy, v0, v1, v2;
			triple_t r;
			sum = iter + seed;
			jx = sum * JIT_X_MUL;
			jy = sum * JIT_Y_MUL;
			v0 = {16'd0, px} + jx % JIT_X_MOD;
			v1 = {16'd0, py} + jy % JIT_Y_MOD;
			v2 = v0 ^ v1;
			v0 = v0 * MIX_LCG_MUL + MIX_LCG_INC;
			v1 = v1 * MIX_LCG_MUL + MIX_LCG_INC;
			v2 = v2 * MIX_LCG_MUL + MIX_LCG_INC;
			v0 = v0 + v1 * v2;
			v1 = v1 + v2 * v0;
			v2 = v2 + v0 * v1;
			v0 = v0 ^ (v0 >> MIX_SHIFT);
			v1 = v1 ^ (v1 >> MIX_SHIFT);
			v2 = v2 ^ (v2 >> MIX_SHIFT);
			v0 = v0 + v1 * v2;
			v1 = v1 + v2 * v0;
			v2 = v2 + v0 * v1;
			r.a = v0;
			r.b = v1;
			r.c = v2;
			return r;
		endfunction

		function void note_input(logic [15:0] px, logic [15:0] py, word_t iter);
			expected_q.push_back(hash_sample(px, py, iter));
		endfunction

		function void check_result(logic [95:0] data);
			triple_t got, want;
			got = data;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result a=%h b=%h c=%h", got.a, got.b, got.c);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.a !== want.a || got.b !== want.b || got.c !== want.c) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("result %0d: expected a=%h b=%h c=%h, got a=%h b=%h c=%h",
						checked, want.a, want.b, want.c, got.a, got.b, got.c);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // pixel_x, pixel_y, iteration
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [95:0] m_axis_tdata;   // rand_a, rand_b, rand_c
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	hash_scoreboard sb = new();
	int cycles = 0;
	int items_sent = 0;
	int seed_settings = 0;
	int send_run_left = 0;
	bit send_calm = 0;
	int recv_run_left = 0;
	bit recv_calm = 0;

	pixel_seeded_pcg3d_hash_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= MAX_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("tb: failure");
			$finish;
		end
	end

	// Gaps come in runs: some runs are gap-free, the rest draw a random gap before each item.
	function automatic int draw_gap(inout int run_left, inout bit calm);
		if (run_left == 0) begin
			run_left = $urandom_range(8, 64);
			calm = ($urandom_range(0, 2) == 0);
		end
		run_left--;
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'hffff - 16'($urandom_range(0, 800));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic push_pixel(input logic [15:0] px, input logic [15:0] py, input word_t iter);
		int gap;
		gap = draw_gap(send_run_left, send_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {iter, py, px};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(px, py, iter);
		items_sent++;
	endtask

	// Hold off the sender until every expected result is back.
	task automatic drain_pipe();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_seed(input word_t value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.seed = value;
		seed_settings++;
	endtask

	// Pixel sample streams: a few consecutive iterations per pixel, sometimes wrapping.
	task automatic run_streams(input int count, input bit pause_mid);
		int left;
		logic [15:0] px, py;
		word_t iter;
		left = 0;
		for (int n = 0; n < count; n++) begin
			if (left == 0) begin
				left = $urandom_range(1, 8);
				px = pick_coord();
				py = pick_coord();
				if ($urandom_range(0, 3) == 0)
					iter = 32'hffffffff - $urandom_range(0, 4);
				else
					iter = $urandom();
			end
			push_pixel(px, py, iter);
			iter++;
			left--;
			if (pause_mid && n == count / 2)
				drain_pipe();
		end
	endtask

	always begin
		int gap;
		gap = draw_gap(recv_run_left, recv_calm);
		if (gap > 0) begin
			m_axis_tready <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		m_axis_tready <= 1'b1;
		do @(posedge clk); while (!m_axis_tvalid);
		sb.check_result(m_axis_tdata);
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// seed left at its reset value
		seed_settings++;
		push_pixel(16'h0000, 16'h0000, 32'h00000000);
		push_pixel(16'hffff, 16'hffff, 32'h00000000);
		push_pixel(16'hffff, 16'h0000, 32'hffffffff);
		push_pixel(16'h0000, 16'hffff, 32'hffffffff);
		push_pixel(16'haaaa, 16'h5555, 32'h80000000);
		push_pixel(16'h5555, 16'haaaa, 32'h7fffffff);
		push_pixel(16'h0001, 16'h0002, 32'h00000003);
		push_pixel(16'hffff, 16'hffff, 32'hffffffff);
		drain_pipe();

		// all-ones seed: iteration plus seed wraps
		write_seed(32'hffffffff);
		push_pixel(16'h0000, 16'h0000, 32'h00000000);
		push_pixel(16'h0000, 16'h0000, 32'h00000001);
		push_pixel(16'hffff, 16'hffff, 32'hffffffff);
		push_pixel(16'hffff, 16'hffff, 32'h00000002);
		push_pixel(16'h04d2, 16'h10e1, 32'h80000000);
		run_streams(300, 1'b0);
		drain_pipe();

		write_seed(32'h00000001);
		run_streams(250, 1'b0);
		drain_pipe();

		write_seed($urandom());
		run_streams(250, 1'b1);
		drain_pipe();

		write_seed(32'h80000000);
		run_streams(250, 1'b0);
		drain_pipe();

		write_seed($urandom());
		run_streams(250, 1'b0);
		drain_pipe();

		write_seed(32'h00000000);
		run_streams(240, 1'b0);
		drain_pipe();

		repeat (24) @(posedge clk);
		$display("%0d pixel samples hashed under %0d seed settings",
			items_sent, seed_settings);
		$display("%0d results checked, %0d errors", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
